// ----- src/vclw_pkg.sv -----
// Shared constants, register indexes and the configuration struct for the
// velocity command limiter with command watchdog. No dependencies.
package vclw_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_FORWARD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_TURN    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_EN    = 2'd3;

  localparam logic [14:0] RST_MAX_FORWARD = 15'd500;
  localparam logic [14:0] RST_MAX_TURN    = 15'd40;
  localparam logic [7:0]  RST_TIMEOUT     = 8'd20;
  localparam logic        RST_MOTOR_EN    = 1'b0;

  localparam logic [1:0] MODE_TICK     = 2'd0;
  localparam logic [1:0] MODE_STATUS   = 2'd1;
  localparam logic [1:0] MODE_SHUTDOWN = 2'd2;
  localparam logic [1:0] MODE_NONE     = 2'd3;

  localparam logic [10:0] FRAME_COMMAND  = 11'h413;
  localparam logic [10:0] FRAME_SHUTDOWN = 11'h412;

  // Saturation limits on counts, and the speed magnitudes at which they apply.
  localparam logic [10:0] FWD_SAT     = 11'd1176;
  localparam logic [10:0] TURN_SAT    = 11'd1024;
  localparam logic [14:0] FWD_SAT_IN  = 15'd3576;
  localparam logic [14:0] TURN_SAT_IN = 15'd132;

  // Fixed-point reciprocals of the scale factors, rounded at elaboration.
  localparam int FWD_SHIFT  = 40;
  localparam int TURN_SHIFT = 16;
  localparam logic [79:0] FWD_RECIP_WIDE =
    ((80'd32882963 << FWD_SHIFT) + 80'd50000000) / 80'd100000000;
  localparam logic [79:0] TURN_RECIP_WIDE = ((80'd39 << TURN_SHIFT) + 80'd2) / 80'd5;
  localparam logic [38:0] FWD_RECIP  = FWD_RECIP_WIDE[38:0];
  localparam logic [19:0] TURN_RECIP = TURN_RECIP_WIDE[19:0];

  typedef struct packed {
    logic [14:0] max_forward;
    logic [14:0] max_turn;
    logic [7:0]  timeout;
    logic        motor_en;
  } cfg_t;

endpackage

// ----- src/vclw_cfg.sv -----
// Configuration register file for the velocity command limiter.
// Depends on vclw_pkg for register indexes, reset values and cfg_t.
module vclw_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wen,
  input  logic [vclw_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [vclw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output vclw_pkg::cfg_t                     cfg
);

  vclw_pkg::cfg_t cfg_r;
  vclw_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wen) begin
      unique case (cfg_index)
        vclw_pkg::REG_MAX_FORWARD: cfg_nxt.max_forward = cfg_wdata;
        vclw_pkg::REG_MAX_TURN:    cfg_nxt.max_turn    = cfg_wdata;
        vclw_pkg::REG_TIMEOUT:     cfg_nxt.timeout     = cfg_wdata[7:0];
        vclw_pkg::REG_MOTOR_EN:    cfg_nxt.motor_en    = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_forward <= vclw_pkg::RST_MAX_FORWARD;
      cfg_r.max_turn    <= vclw_pkg::RST_MAX_TURN;
      cfg_r.timeout     <= vclw_pkg::RST_TIMEOUT;
      cfg_r.motor_en    <= vclw_pkg::RST_MOTOR_EN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/vclw_scale.sv -----
// Converts clamped speeds to saturated device counts with round-to-nearest.
// Depends on vclw_pkg for the reciprocal constants and saturation limits.
module vclw_scale (
  input  logic signed [15:0] fwd_speed,
  input  logic signed [15:0] turn_speed,
  output logic signed [11:0] forward_count,
  output logic signed [11:0] turn_count
);

  logic        fwd_neg;
  logic        turn_neg;
  logic [15:0] fwd_neg_val;
  logic [15:0] turn_neg_val;
  logic [14:0] fwd_abs;
  logic [14:0] turn_abs;
  logic [50:0] fwd_prod;
  logic [51:0] fwd_sum;
  logic [27:0] turn_prod;
  logic [28:0] turn_sum;
  logic [10:0] fwd_mag;
  logic [10:0] turn_mag;

  assign fwd_neg      = fwd_speed[15];
  assign turn_neg     = turn_speed[15];
  assign fwd_neg_val  = 16'(-fwd_speed);
  assign turn_neg_val = 16'(-turn_speed);
  assign fwd_abs      = fwd_neg ? fwd_neg_val[14:0] : fwd_speed[14:0];
  assign turn_abs     = turn_neg ? turn_neg_val[14:0] : turn_speed[14:0];

  // Beyond the saturation inputs the multiply is skipped, so it stays narrow.
  assign fwd_prod  = 51'(fwd_abs[11:0]) * 51'(vclw_pkg::FWD_RECIP);
  assign fwd_sum   = 52'(fwd_prod) + (52'd1 << (vclw_pkg::FWD_SHIFT - 1));
  assign turn_prod = 28'(turn_abs[7:0]) * 28'(vclw_pkg::TURN_RECIP);
  assign turn_sum  = 29'(turn_prod) + (29'd1 << (vclw_pkg::TURN_SHIFT - 1));

  assign fwd_mag  = (fwd_abs >= vclw_pkg::FWD_SAT_IN) ? vclw_pkg::FWD_SAT :
                    fwd_sum[vclw_pkg::FWD_SHIFT+10:vclw_pkg::FWD_SHIFT];
  assign turn_mag = (turn_abs >= vclw_pkg::TURN_SAT_IN) ? vclw_pkg::TURN_SAT :
                    turn_sum[vclw_pkg::TURN_SHIFT+10:vclw_pkg::TURN_SHIFT];

  assign forward_count = fwd_neg ? 12'(-{1'b0, fwd_mag}) : {1'b0, fwd_mag};
  assign turn_count    = turn_neg ? 12'(-{1'b0, turn_mag}) : {1'b0, turn_mag};

endmodule

// ----- src/velocity_command_limiter_watchdog.sv -----
// Top level of the velocity command limiter with command watchdog.
// Depends on vclw_pkg, vclw_cfg and vclw_scale.
//
// Each request on the in_ channel is a control tick, a status request or a
// shutdown request, selected by in_tuser. A tick either brings new speeds or
// reuses the stored ones and advances the idle counter; at the timeout limit,
// or with the motor disabled, the speeds are forced to zero. Speeds are
// clamped to the configured maxima, stored, and scaled to device counts.
// Every request except the unused mode three yields one frame on out_.
// A request is taken into an input register, worked in one pass of logic
// and placed in the result register, which drives out_tvalid. One request is
// accepted every cycle while out_tready stays high. When the receiver stalls,
// the result register holds its frame and the input register still takes one
// more request before in_tready drops. Reset clears the stored speeds and idle
// counter and loads the register defaults. The user must write the
// configuration port only while the block is idle, which it does not enforce.
module velocity_command_limiter_watchdog (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wen,
  input  logic [vclw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vclw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [0] has_command, [16:1] new_forward_speed, [32:17] new_turn_speed,
  // [48:33] status_code, [56:49] status_value, [71:57] zero
  input  logic [71:0]                      in_tdata,
  // [1:0] mode
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [11:0] forward_count, [23:12] turn_count, [39:24] command_word,
  // [47:40] command_byte, [48] timed_out, [55:49] zero
  output logic [55:0]                      out_tdata,
  // [10:0] frame_id
  output logic [10:0]                      out_tuser
);

  vclw_pkg::cfg_t cfg;

  logic               s1_valid_r;
  logic [1:0]         s1_mode_r;
  logic               s1_has_cmd_r;
  logic signed [15:0] s1_fwd_r;
  logic signed [15:0] s1_turn_r;
  logic [15:0]        s1_code_r;
  logic [7:0]         s1_value_r;

  logic signed [15:0] stored_fwd_r;
  logic signed [15:0] stored_turn_r;
  logic [7:0]         idle_r;
  logic signed [15:0] stored_fwd_nxt;
  logic signed [15:0] stored_turn_nxt;
  logic [7:0]         idle_nxt;

  logic               out_valid_r;
  logic [10:0]        out_id_r;
  logic [11:0]        out_fwd_r;
  logic [11:0]        out_turn_r;
  logic [15:0]        out_word_r;
  logic [7:0]         out_byte_r;
  logic               out_to_r;
  logic               out_valid_nxt;
  logic [10:0]        out_id_nxt;
  logic [11:0]        out_fwd_nxt;
  logic [11:0]        out_turn_nxt;
  logic [15:0]        out_word_nxt;
  logic [7:0]         out_byte_nxt;
  logic               out_to_nxt;

  logic               out_free;
  logic               s1_drop;
  logic               s1_fire;
  logic               s1_load;
  logic               tick_fire;
  logic               in_fire;

  logic [8:0]         cnt_inc;
  logic               force_stop;
  logic               idle_at_limit;
  logic signed [15:0] fwd_pick;
  logic signed [15:0] turn_pick;
  logic signed [16:0] fwd_lim;
  logic signed [16:0] turn_lim;
  logic signed [16:0] fwd_wide;
  logic signed [16:0] turn_wide;
  logic signed [15:0] fwd_scale_in;
  logic signed [15:0] turn_scale_in;
  logic signed [11:0] fwd_count;
  logic signed [11:0] turn_count;

  vclw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign s1_drop   = (s1_mode_r == vclw_pkg::MODE_NONE);
  assign s1_fire   = s1_valid_r && (s1_drop || out_free);
  assign s1_load   = s1_fire && !s1_drop;
  assign tick_fire = s1_fire && (s1_mode_r == vclw_pkg::MODE_TICK);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  // Watchdog counter: a new command clears it, otherwise it advances and
  // saturates at the timeout limit, where it forces a stop.
  assign cnt_inc       = s1_has_cmd_r ? 9'd0 : ({1'b0, idle_r} + 9'd1);
  assign force_stop    = (cnt_inc >= {1'b0, cfg.timeout});
  assign idle_nxt      = force_stop ? cfg.timeout : cnt_inc[7:0];
  assign idle_at_limit = (idle_r >= cfg.timeout);

  always_comb begin
    fwd_pick  = s1_has_cmd_r ? s1_fwd_r : stored_fwd_r;
    turn_pick = s1_has_cmd_r ? s1_turn_r : stored_turn_r;
    if (force_stop || !cfg.motor_en) begin
      fwd_pick  = 16'sd0;
      turn_pick = 16'sd0;
    end
  end

  assign fwd_lim   = signed'({2'b00, cfg.max_forward});
  assign turn_lim  = signed'({2'b00, cfg.max_turn});
  assign fwd_wide  = 17'(fwd_pick);
  assign turn_wide = 17'(turn_pick);

  always_comb begin
    if (fwd_wide > fwd_lim) begin
      stored_fwd_nxt = fwd_lim[15:0];
    end else if (fwd_wide < -fwd_lim) begin
      stored_fwd_nxt = 16'(-fwd_lim);
    end else begin
      stored_fwd_nxt = fwd_pick;
    end
    if (turn_wide > turn_lim) begin
      stored_turn_nxt = turn_lim[15:0];
    end else if (turn_wide < -turn_lim) begin
      stored_turn_nxt = 16'(-turn_lim);
    end else begin
      stored_turn_nxt = turn_pick;
    end
  end

  assign fwd_scale_in  = (s1_mode_r == vclw_pkg::MODE_TICK) ? stored_fwd_nxt : stored_fwd_r;
  assign turn_scale_in = (s1_mode_r == vclw_pkg::MODE_TICK) ? stored_turn_nxt : stored_turn_r;

  vclw_scale u_scale (
    .fwd_speed     (fwd_scale_in),
    .turn_speed    (turn_scale_in),
    .forward_count (fwd_count),
    .turn_count    (turn_count)
  );

  always_comb begin
    out_id_nxt   = vclw_pkg::FRAME_COMMAND;
    out_fwd_nxt  = fwd_count;
    out_turn_nxt = turn_count;
    out_word_nxt = 16'd0;
    out_byte_nxt = 8'd0;
    out_to_nxt   = idle_at_limit;
    unique case (s1_mode_r)
      vclw_pkg::MODE_TICK: begin
        out_to_nxt = force_stop;
      end
      vclw_pkg::MODE_STATUS: begin
        out_word_nxt = s1_code_r;
        out_byte_nxt = s1_value_r;
      end
      default: begin
        out_id_nxt   = vclw_pkg::FRAME_SHUTDOWN;
        out_fwd_nxt  = 12'd0;
        out_turn_nxt = 12'd0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      stored_fwd_r  <= 16'sd0;
      stored_turn_r <= 16'sd0;
      idle_r        <= 8'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (tick_fire) begin
        stored_fwd_r  <= stored_fwd_nxt;
        stored_turn_r <= stored_turn_nxt;
        idle_r        <= idle_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r    <= in_tuser;
      s1_has_cmd_r <= in_tdata[0];
      s1_fwd_r     <= in_tdata[16:1];
      s1_turn_r    <= in_tdata[32:17];
      s1_code_r    <= in_tdata[48:33];
      s1_value_r   <= in_tdata[56:49];
    end
    if (s1_load) begin
      out_id_r   <= out_id_nxt;
      out_fwd_r  <= out_fwd_nxt;
      out_turn_r <= out_turn_nxt;
      out_word_r <= out_word_nxt;
      out_byte_r <= out_byte_nxt;
      out_to_r   <= out_to_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_id_r;
  assign out_tdata  = {7'd0, out_to_r, out_byte_r, out_word_r, out_turn_r, out_fwd_r};

  a_idle_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    tick_fire |=> idle_r <= $past(cfg.timeout))
    else $error("idle counter above timeout limit after a tick");

  a_fwd_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    tick_fire |=> (int'(stored_fwd_r) <= int'($past(cfg.max_forward))) &&
                  (int'(stored_fwd_r) >= -int'($past(cfg.max_forward))))
    else $error("stored forward speed outside its limit");

  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    tick_fire && !cfg.motor_en |=> stored_fwd_r == 16'sd0 && stored_turn_r == 16'sd0)
    else $error("disabled motor left nonzero stored speeds");

  a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    tick_fire && force_stop |=> out_fwd_r == 12'd0 && out_turn_r == 12'd0 && out_to_r)
    else $error("timed out tick produced nonzero counts");

  a_shutdown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_id_r == vclw_pkg::FRAME_SHUTDOWN |->
      out_fwd_r == 12'd0 && out_turn_r == 12'd0 && out_word_r == 16'd0 &&
      out_byte_r == 8'd0)
    else $error("shutdown frame carries nonzero fields");

endmodule
